### src/clm_pkg.sv
// shared constants, codes and item types for the card loom magnet sequencer
// no dependencies; every other file except clm_store uses it by scoped names
package clm_pkg;

    localparam int MAX_LINES_DEF = 256;
    localparam int MAGNET_COUNT  = 24;
    localparam int PATTERN_W     = 24;
    localparam int INDEX_W       = 8;
    localparam int TICK_W        = 8;
    localparam int CFG_DATA_W    = 9;
    localparam int CFG_INDEX_W   = 2;
    localparam int STATE_W       = 3;

    localparam logic [PATTERN_W-1:0] MAGNET_MASK = (MAGNET_COUNT >= PATTERN_W) ? '1
        : PATTERN_W'((64'd1 << MAGNET_COUNT) - 64'd1);

    // state codes as seen on the result channel
    localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] ST_DRIVE = 3'd1;
    localparam logic [STATE_W-1:0] ST_PAUSE = 3'd2;
    localparam logic [STATE_W-1:0] ST_NEXT  = 3'd3;
    localparam logic [STATE_W-1:0] ST_EMERG = 3'd4;

    localparam logic OP_CTRL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_LINES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION = 2'd2;

    localparam logic [TICK_W-1:0] TIMEOUT_RST = 8'd3;

    typedef struct packed {
        logic                 opcode;
        logic [INDEX_W-1:0]   card_line_index;
        logic [PATTERN_W-1:0] card_line_pattern;
        logic                 emergency;
        logic                 start_req;
        logic                 end_request;
        logic                 pause_request;
        logic                 resume;
        logic                 restart;
        logic                 sensor;
        logic                 tick;
    } item_t;

    typedef struct packed {
        logic [STATE_W-1:0]   state_code;
        logic [INDEX_W-1:0]   line_index;
        logic [PATTERN_W-1:0] magnet_drive;
        logic                 paused;
    } result_t;

endpackage

### src/clm_if.sv
// valid/ready channels for input items and result items
// depends on clm_pkg for the payload types
interface clm_item_if;
    logic          valid;
    logic          ready;
    clm_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface clm_result_if;
    logic            valid;
    logic            ready;
    clm_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/clm_store.sv
// card store: one write port, one registered read port with write-first bypass
// depends on nothing; sized by the top level
module clm_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 24
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/clm_fsm.sv
// sequencer state machine, line counter, tick counter and configuration registers
// depends on clm_pkg; its state registers double as the result register
module clm_fsm #(
    parameter int MAX_LINES = clm_pkg::MAX_LINES_DEF,
    parameter int LINE_W    = $clog2(MAX_LINES)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [clm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [clm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               fire,
    input  clm_pkg::item_t                     item_data,
    output logic [LINE_W-1:0]                  line_next_out,
    output logic [LINE_W-1:0]                  line_cur,
    output logic [clm_pkg::STATE_W-1:0]        state_cur
);

    localparam int CNT_W = LINE_W + 1;
    localparam int NW    = (CNT_W > clm_pkg::CFG_DATA_W) ? CNT_W : clm_pkg::CFG_DATA_W;

    typedef enum logic [clm_pkg::STATE_W-1:0] {
        S_IDLE  = clm_pkg::ST_IDLE,
        S_DRIVE = clm_pkg::ST_DRIVE,
        S_PAUSE = clm_pkg::ST_PAUSE,
        S_NEXT  = clm_pkg::ST_NEXT,
        S_EMERG = clm_pkg::ST_EMERG
    } state_t;

    state_t                      state_reg, state_next;
    state_t                      saved_reg, saved_next;
    logic [LINE_W-1:0]           line_reg, line_next;
    logic [clm_pkg::TICK_W-1:0]  elapsed_reg, elapsed_next, elapsed_inc;
    logic [clm_pkg::TICK_W-1:0]  timeout_reg;
    logic [CNT_W-1:0]            lines_reg;
    logic                        fwd_reg;
    logic                        timeout;
    logic [CNT_W-1:0]            line_inc;
    logic [LINE_W-1:0]           line_step;
    logic [NW-1:0]               lines_raw;
    logic [CNT_W-1:0]            lines_clamped;

    // line count clamped to 1 .. MAX_LINES when written
    always_comb
    begin
        lines_raw = NW'(cfg_data);
        if (lines_raw == '0)
        begin
            lines_clamped = CNT_W'(1);
        end
        else if (lines_raw > NW'(MAX_LINES))
        begin
            lines_clamped = CNT_W'(MAX_LINES);
        end
        else
        begin
            lines_clamped = CNT_W'(lines_raw);
        end
    end

    // one step of the line index with wrap
    always_comb
    begin
        line_inc = CNT_W'(line_reg) + CNT_W'(1);
        if (fwd_reg)
        begin
            line_step = (line_inc >= lines_reg) ? '0 : LINE_W'(line_inc);
        end
        else
        begin
            line_step = (line_reg == '0) ? LINE_W'(lines_reg - CNT_W'(1))
                                         : line_reg - LINE_W'(1);
        end
    end

    always_comb
    begin
        elapsed_inc = (item_data.tick && (elapsed_reg != '1)) ? elapsed_reg + 8'd1
                                                              : elapsed_reg;
        timeout      = elapsed_inc > timeout_reg;
        state_next   = state_reg;
        saved_next   = saved_reg;
        line_next    = line_reg;
        elapsed_next = elapsed_reg;
        if (fire && (item_data.opcode == clm_pkg::OP_CTRL))
        begin
            elapsed_next = elapsed_inc;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_data.emergency)
                    begin
                        saved_next = S_IDLE;
                        state_next = S_EMERG;
                    end
                    else if (item_data.start_req)
                    begin
                        elapsed_next = '0;
                        state_next   = S_DRIVE;
                    end
                end
                S_DRIVE:
                begin
                    if (item_data.emergency)
                    begin
                        saved_next = S_PAUSE;
                        state_next = S_EMERG;
                    end
                    else if (item_data.end_request)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (item_data.pause_request || timeout)
                    begin
                        state_next = S_PAUSE;
                    end
                    else if (item_data.sensor)
                    begin
                        state_next = S_NEXT;
                    end
                end
                S_PAUSE:
                begin
                    if (item_data.emergency)
                    begin
                        saved_next = S_PAUSE;
                        state_next = S_EMERG;
                    end
                    else if (item_data.end_request)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (item_data.resume)
                    begin
                        elapsed_next = '0;
                        state_next   = S_DRIVE;
                    end
                end
                S_NEXT:
                begin
                    if (item_data.emergency)
                    begin
                        saved_next = S_PAUSE;
                        state_next = S_EMERG;
                    end
                    else if (item_data.end_request)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!item_data.sensor)
                    begin
                        line_next    = line_step;
                        elapsed_next = '0;
                        state_next   = S_DRIVE;
                    end
                end
                S_EMERG:
                begin
                    if (item_data.end_request)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (item_data.restart)
                    begin
                        state_next = saved_reg;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
            if (state_next == S_IDLE)
            begin
                line_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            saved_reg   <= S_IDLE;
            line_reg    <= '0;
            elapsed_reg <= '0;
            timeout_reg <= clm_pkg::TIMEOUT_RST;
            lines_reg   <= CNT_W'(1);
            fwd_reg     <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            saved_reg   <= saved_next;
            line_reg    <= line_next;
            elapsed_reg <= elapsed_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    clm_pkg::CFG_TIMEOUT:   timeout_reg <= clm_pkg::TICK_W'(cfg_data);
                    clm_pkg::CFG_NUM_LINES: lines_reg   <= lines_clamped;
                    clm_pkg::CFG_DIRECTION: fwd_reg     <= cfg_data[0];
                    default:                ;
                endcase
            end
        end
    end

    assign line_next_out = line_next;
    assign line_cur      = line_reg;
    assign state_cur     = state_reg;

endmodule

### src/card_loom_magnet_sequencer.sv
// top level of the card loom magnet sequencer: input register, handshake, result channel
// depends on clm_pkg, clm_if, clm_fsm and clm_store
//
//  channel   dir   handshake      payload
//  item      in    valid/ready    clm_pkg::item_t
//  result    out   valid/ready    clm_pkg::result_t
//  cfg       in    cfg_wr_en      cfg_index, cfg_data
//
// one item a cycle unless the result stalls; an item passes both stages in order
// stage one is the input register, stage two the state update and card store read
// reset empties both stages and loads the register defaults; the store is not cleared
// a stalled result holds both stages while the input register has an item in it
module card_loom_magnet_sequencer #(
    parameter int MAX_LINES = clm_pkg::MAX_LINES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [clm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clm_pkg::CFG_DATA_W-1:0]  cfg_data,
    clm_item_if.sink                        item,
    clm_result_if.source                    result
);

    localparam int LINE_W = $clog2(MAX_LINES);

    logic                           in_valid_reg;
    clm_pkg::item_t                 item_reg;
    logic                           out_valid_reg;
    logic                           advance;
    logic                           fire;
    logic                           wr_en;
    logic [LINE_W-1:0]              wr_addr;
    logic [LINE_W-1:0]              line_next;
    logic [LINE_W-1:0]              line_cur;
    logic [clm_pkg::STATE_W-1:0]    state_cur;
    logic [clm_pkg::PATTERN_W-1:0]  rd_data;

    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || advance;
    assign fire       = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item.data;
        end
    end

    // writes beyond the store are dropped
    assign wr_en   = fire && (item_reg.opcode == clm_pkg::OP_WRITE)
                     && (32'(item_reg.card_line_index) < 32'(MAX_LINES));
    assign wr_addr = LINE_W'(item_reg.card_line_index);

    clm_fsm #(
        .MAX_LINES (MAX_LINES),
        .LINE_W    (LINE_W)
    ) u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fire          (fire),
        .item_data     (item_reg),
        .line_next_out (line_next),
        .line_cur      (line_cur),
        .state_cur     (state_cur)
    );

    clm_store #(
        .DEPTH  (MAX_LINES),
        .ADDR_W (LINE_W),
        .DATA_W (clm_pkg::PATTERN_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_reg.card_line_pattern & clm_pkg::MAGNET_MASK),
        .rd_en   (fire),
        .rd_addr (line_next),
        .rd_data (rd_data)
    );

    assign result.valid             = out_valid_reg;
    assign result.data.state_code   = state_cur;
    assign result.data.line_index   = clm_pkg::INDEX_W'(line_cur);
    assign result.data.magnet_drive = (state_cur == clm_pkg::ST_DRIVE) ? rd_data : '0;
    assign result.data.paused       = (state_cur == clm_pkg::ST_PAUSE);

endmodule

### src/clm_checker.sv
// port-level checks on the result channel of the sequencer, bound to the top level
// depends on clm_pkg for codes and the result type
module clm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input clm_pkg::result_t out_data
);

    // magnets are quiet outside the drive state
    a_magnets_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.state_code != clm_pkg::ST_DRIVE)
        |-> (out_data.magnet_drive == '0))
        else $error("magnets driven outside drive state");

    // idle always sits on the first line
    a_idle_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.state_code == clm_pkg::ST_IDLE)
        |-> (out_data.line_index == '0))
        else $error("line index not cleared in idle");

    // pause flag tracks the pause state
    a_paused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.paused == (out_data.state_code == clm_pkg::ST_PAUSE)))
        else $error("pause flag disagrees with state");

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind card_loom_magnet_sequencer clm_checker u_clm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
